// File: rtl/clt_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the command-line tokenizer.
// Used by clt_out_stage and command_line_tokenizer; depends on nothing else.
package clt_pkg;

    localparam int BYTE_W  = 8;
    localparam int ARG_W   = 8;
    localparam int RUN_W   = 6;
    localparam int CFG_IDX_W = 1;
    localparam int DATA_W  = BYTE_W + ARG_W;
    localparam int USER_W  = 3;

    localparam logic [RUN_W-1:0]  RUN_MAX   = 6'd62;
    localparam logic [BYTE_W-1:0] NUL_CH    = 8'h00;
    localparam logic [BYTE_W-1:0] QUOTE_CH  = 8'h22;
    localparam logic [BYTE_W-1:0] BSLASH_CH = 8'h5C;

    localparam logic [CFG_IDX_W-1:0] REG_START_INDEX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ARG_LIMIT   = 1'b1;

    localparam logic [ARG_W-1:0] START_INDEX_RESET = 8'd1;
    localparam logic [ARG_W-1:0] ARG_LIMIT_RESET   = 8'd49;

    // One result before the last flag is known.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              tend;
        logic [ARG_W-1:0]  argn;
        logic              limit;
        logic              ovf;
    } result_t;

    // Status of the output stage as seen by the sequencer.
    typedef struct packed {
        logic ok;
        logic pend_valid;
    } emit_stat_t;

    function automatic logic is_space(input logic [BYTE_W-1:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

// File: rtl/clt_out_stage.sv
`timescale 1ns / 1ps
// Output stage of the tokenizer: a pending register that holds the newest result
// until it is known whether it is the last one, and the master-side register. Uses clt_pkg.
module clt_out_stage (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  clt_pkg::result_t            push_res,
    input  logic                        flush,
    output clt_pkg::emit_stat_t         stat,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [clt_pkg::DATA_W-1:0]  m_tdata,  // out_byte[7:0], arg_number[15:8]
    output logic [clt_pkg::USER_W-1:0]  m_tuser,  // token_end, limit_reached, run_overflow
    output logic                        m_tlast
);
    import clt_pkg::*;

    logic    pend_valid_reg, pend_valid_next;
    logic    out_valid_reg, out_valid_next;
    result_t pend_reg, pend_next;
    result_t out_reg, out_next;
    logic    last_reg, last_next;
    logic    out_free;
    logic    ok;

    assign out_free = !out_valid_reg || m_tready;
    assign ok       = !pend_valid_reg || out_free;

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        pend_next       = pend_reg;
        out_next        = out_reg;
        last_next       = last_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (push && ok)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                last_next      = 1'b0;
                out_valid_next = 1'b1;
            end
            pend_next       = push_res;
            pend_valid_next = 1'b1;
        end
        else if (flush && ok && pend_valid_reg)
        begin
            out_next        = pend_reg;
            last_next       = 1'b1;
            out_valid_next  = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        last_reg <= last_next;
    end

    assign stat.ok         = ok;
    assign stat.pend_valid = pend_valid_reg;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.argn, out_reg.data};
    assign m_tuser  = {out_reg.ovf, out_reg.limit, out_reg.tend};
    assign m_tlast  = last_reg;

endmodule

// File: rtl/command_line_tokenizer.sv
`timescale 1ns / 1ps
// Top level of the command-line tokenizer: byte sequencer, line state and configuration.
// Depends on clt_pkg and clt_out_stage.
//
// Usage
// The slave side takes one command-line byte per transaction in s_tdata, with s_tlast
// marking the final byte of the line; a zero byte also ends the line. The master side
// delivers one result per transaction: the token byte and argument number in m_tdata,
// token_end, limit_reached and run_overflow in m_tuser, and m_tlast on the final result
// that one input byte causes. A byte that causes no result gives no transaction.
// The configuration port writes start_index (index 0, also loads the argument counter)
// and arg_limit (index 1) at any edge with cfg_we high; write only while the block is idle.
//
// Timing
// One input byte is handled by a small sequencer that emits at most one result per cycle.
// A plain character passes through S_BS1, S_CH and S_FLUSH before s_tready rises again, and a
// pending backslash run is emitted in S_BS1 first, one result per backslash (half the run
// before a quote). A counted backslash, or a byte ignored once the limit is reached, goes
// straight to S_FLUSH. A line end adds S_EOL, S_BS2 and S_CL (only S_EOL once parsing has
// stopped), and S_BS2 emits the backslashes it flushes.
// The last result of a byte is held in a pending register until the byte is done, so a
// result passes through the pending register and then the output register to m_tvalid; it
// leaves the pending register at the next result or in S_FLUSH, after any line-end states.
// When the receiver stalls, the sequencer holds as soon as both the pending and the
// output register are full, and s_tready stays low until the byte is fully handled.
// Reset clears the line state, loads start_index 1 and arg_limit 49, and empties the
// output side.
module command_line_tokenizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [clt_pkg::BYTE_W-1:0]     s_tdata,   // in_byte[7:0]
    input  logic                           s_tlast,   // end_of_line
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [clt_pkg::DATA_W-1:0]     m_tdata,   // out_byte[7:0], arg_number[15:8]
    output logic [clt_pkg::USER_W-1:0]     m_tuser,   // token_end, limit_reached, run_overflow
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [clt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [clt_pkg::ARG_W-1:0]      cfg_data
);
    import clt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BS1,
        S_CH,
        S_EOL,
        S_BS2,
        S_CL,
        S_FLUSH
    } state_t;

    state_t            state_reg, state_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              eol_reg, eol_next;
    logic              odd_reg, odd_next;
    logic [RUN_W-1:0]  cnt_reg, cnt_next;
    logic [RUN_W-1:0]  run_reg, run_next;
    logic              quotes_reg, quotes_next;
    logic              open_reg, open_next;
    logic [ARG_W-1:0]  arg_reg, arg_next;
    logic              stopped_reg, stopped_next;
    logic              ovf_reg, ovf_next;
    logic [ARG_W-1:0]  start_reg, start_next;
    logic [ARG_W-1:0]  limit_reg, limit_next;

    logic              push;
    logic              flush;
    result_t           res;
    emit_stat_t        stat;
    result_t           byte_res;
    result_t           close_res;
    logic [ARG_W-1:0]  arg_inc;

    assign s_tready = (state_reg == S_IDLE);
    assign arg_inc  = arg_reg + 8'd1;

    // A literal byte appended to the current token.
    always_comb
    begin
        byte_res.data  = byte_reg;
        byte_res.tend  = 1'b0;
        byte_res.argn  = arg_reg;
        byte_res.limit = stopped_reg;
        byte_res.ovf   = ovf_reg;
    end

    // The close of a token reports the limit as it stands after the counter moves.
    always_comb
    begin
        close_res.data  = NUL_CH;
        close_res.tend  = 1'b1;
        close_res.argn  = arg_reg;
        close_res.limit = stopped_reg || (arg_inc == limit_reg);
        close_res.ovf   = ovf_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        byte_next    = byte_reg;
        eol_next     = eol_reg;
        odd_next     = odd_reg;
        cnt_next     = cnt_reg;
        run_next     = run_reg;
        quotes_next  = quotes_reg;
        open_next    = open_reg;
        arg_next     = arg_reg;
        stopped_next = stopped_reg;
        ovf_next     = ovf_reg;
        start_next   = start_reg;
        limit_next   = limit_reg;
        push         = 1'b0;
        flush        = 1'b0;
        res          = byte_res;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    byte_next = s_tdata;
                    eol_next  = s_tlast || (s_tdata == NUL_CH);
                    if ((s_tdata != NUL_CH) && !stopped_reg)
                    begin
                        if (s_tdata == BSLASH_CH)
                        begin
                            if (run_reg < RUN_MAX)
                            begin
                                run_next = run_reg + 6'd1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            state_next = (s_tlast) ? S_EOL : S_FLUSH;
                        end
                        else
                        begin
                            // A quote halves the run; anything else keeps it whole.
                            cnt_next   = (s_tdata == QUOTE_CH) ? (run_reg >> 1) : run_reg;
                            odd_next   = run_reg[0];
                            run_next   = '0;
                            state_next = S_BS1;
                        end
                    end
                    else
                    begin
                        state_next = (s_tlast || (s_tdata == NUL_CH)) ? S_EOL : S_FLUSH;
                    end
                end
            end

            S_BS1,
            S_BS2:
            begin
                if (cnt_reg != '0)
                begin
                    if (stat.ok)
                    begin
                        res          = byte_res;
                        res.data     = BSLASH_CH;
                        push         = 1'b1;
                        open_next    = 1'b1;
                        cnt_next     = cnt_reg - 6'd1;
                    end
                end
                else
                begin
                    state_next = (state_reg == S_BS1) ? S_CH : S_CL;
                end
            end

            S_CH:
            begin
                if ((byte_reg == QUOTE_CH) && !odd_reg)
                begin
                    quotes_next = !quotes_reg;
                    state_next  = eol_reg ? S_EOL : S_FLUSH;
                end
                else if (byte_reg == QUOTE_CH)
                begin
                    if (stat.ok)
                    begin
                        res        = byte_res;
                        push       = 1'b1;
                        open_next  = 1'b1;
                        state_next = eol_reg ? S_EOL : S_FLUSH;
                    end
                end
                else if (is_space(byte_reg) && !quotes_reg)
                begin
                    if (!open_reg)
                    begin
                        state_next = eol_reg ? S_EOL : S_FLUSH;
                    end
                    else if (stat.ok)
                    begin
                        res          = close_res;
                        push         = 1'b1;
                        open_next    = 1'b0;
                        arg_next     = arg_inc;
                        stopped_next = close_res.limit;
                        state_next   = eol_reg ? S_EOL : S_FLUSH;
                    end
                end
                else if (stat.ok)
                begin
                    res        = byte_res;
                    push       = 1'b1;
                    open_next  = 1'b1;
                    state_next = eol_reg ? S_EOL : S_FLUSH;
                end
            end

            S_EOL:
            begin
                if (stopped_reg)
                begin
                    // Once stopped, the line end clears the state without results.
                    quotes_next  = 1'b0;
                    run_next     = '0;
                    open_next    = 1'b0;
                    arg_next     = start_reg;
                    stopped_next = 1'b0;
                    ovf_next     = 1'b0;
                    state_next   = S_FLUSH;
                end
                else
                begin
                    // A run left pending at the line end is emitted literally.
                    cnt_next   = run_reg;
                    run_next   = '0;
                    state_next = S_BS2;
                end
            end

            S_CL:
            begin
                if (!open_reg || stat.ok)
                begin
                    if (open_reg)
                    begin
                        res  = close_res;
                        push = 1'b1;
                    end
                    quotes_next  = 1'b0;
                    run_next     = '0;
                    open_next    = 1'b0;
                    arg_next     = start_reg;
                    stopped_next = 1'b0;
                    ovf_next     = 1'b0;
                    state_next   = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                if (stat.ok)
                begin
                    flush      = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (cfg_index == REG_START_INDEX)
            begin
                start_next = cfg_data;
                arg_next   = cfg_data;
            end
            else if (cfg_index == REG_ARG_LIMIT)
            begin
                limit_next = cfg_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            run_reg     <= '0;
            quotes_reg  <= 1'b0;
            open_reg    <= 1'b0;
            arg_reg     <= START_INDEX_RESET;
            stopped_reg <= 1'b0;
            ovf_reg     <= 1'b0;
            start_reg   <= START_INDEX_RESET;
            limit_reg   <= ARG_LIMIT_RESET;
            cnt_reg     <= '0;
            odd_reg     <= 1'b0;
            eol_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            run_reg     <= run_next;
            quotes_reg  <= quotes_next;
            open_reg    <= open_next;
            arg_reg     <= arg_next;
            stopped_reg <= stopped_next;
            ovf_reg     <= ovf_next;
            start_reg   <= start_next;
            limit_reg   <= limit_next;
            cnt_reg     <= cnt_next;
            odd_reg     <= odd_next;
            eol_reg     <= eol_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    clt_out_stage u_out_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (res),
        .flush    (flush),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Every result of the previous byte has been handed on before a new byte is taken.
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !stat.pend_valid)
        else $error("pending result left behind at idle");

    // The backslash run saturates and never passes its maximum.
    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg <= RUN_MAX)
        else $error("backslash run above its maximum");

    // A start_index write loads the argument counter in the next cycle.
    a_start_loads_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && (cfg_index == REG_START_INDEX)) |=> (arg_reg == $past(cfg_data)))
        else $error("argument counter not loaded by start_index write");

    // Parsing stops only on a token close, so no token can be open while stopped.
    a_stopped_closed: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |-> !open_reg)
        else $error("token open while parsing is stopped");

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for command_line_tokenizer: streams command-line bytes in,
// predicts every token result in step with the block and compares each result field by field.
// Depends on clt_pkg and the command_line_tokenizer RTL only.
module testbench;
    import clt_pkg::*;

    localparam int PERIOD       = 4;
    localparam int RESET_CYCLES = 12;
    // Percentage of cycles in which either side holds off.
    localparam int IDLE_PCT     = 37;
    // A byte may leave no result behind while the block still works on it, such as a full
    // backslash run plus the line-end flush; drain waits out this settling time afterwards.
    localparam int SETTLE_CYCLES = 100;
    // Consecutive cycles without any transaction before the run is declared hung.
    localparam int QUIET_LIMIT  = 4000;
    localparam int MAX_RESULTS  = 64;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 18;

    localparam logic [BYTE_W-1:0] TAB_CH   = 8'h09;
    localparam logic [BYTE_W-1:0] VT_CH    = 8'h0B;
    localparam logic [BYTE_W-1:0] CR_CH    = 8'h0D;
    localparam logic [BYTE_W-1:0] SPACE_CH = 8'h20;

    // One byte of the command line as the sender presents it.
    typedef struct packed {
        logic [BYTE_W-1:0] ch;
        logic              eol;
    } line_char_t;

    // One result as it should appear on the master side.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              token_end;
        logic [ARG_W-1:0]  arg_number;
        logic              limit_reached;
        logic              run_overflow;
        logic              last;
    } token_result_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [DATA_W-1:0]     m_tdata;    // out_byte[7:0], arg_number[15:8]
    logic [USER_W-1:0]     m_tuser;    // token_end, limit_reached, run_overflow
    logic                  m_tlast;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ARG_W-1:0]      cfg_data  = '0;

    // Bytes waiting for the sender, and results that the tokenizer still owes us.
    line_char_t    pending_chars[$];
    token_result_t expected_results[$];
    token_result_t burst[$];

    int errors       = 0;
    int quiet_cycles = 0;
    int items_queued = 0;
    // When set, neither side inserts idle cycles.
    bit steady       = 1'b0;

    // Shadow copy of the tokenizer's configuration and line state.
    logic [ARG_W-1:0] first_arg;
    logic [ARG_W-1:0] stop_arg;
    logic             quoted;
    logic [RUN_W-1:0] slash_run;
    logic             arg_open;
    logic [ARG_W-1:0] arg_count;
    logic             halted;
    logic             saturated;

    command_line_tokenizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------

    // Records one result; the limit and overflow flags reflect the state at that moment.
    function automatic void add_result(logic [BYTE_W-1:0] b, logic tend, logic [ARG_W-1:0] argn);
        token_result_t r;
        if (burst.size() >= MAX_RESULTS)
            return;
        r.out_byte      = b;
        r.token_end     = tend;
        r.arg_number    = argn;
        r.limit_reached = halted;
        r.run_overflow  = saturated;
        r.last          = 1'b0;
        burst.push_back(r);
    endfunction

    function automatic void append_char(logic [BYTE_W-1:0] c);
        arg_open = 1'b1;
        add_result(c, 1'b0, arg_count);
    endfunction

    function automatic void emit_slashes(logic [RUN_W-1:0] k);
        for (int i = 0; i < k; i++)
            append_char(BSLASH_CH);
    endfunction

    // Closes a nonempty token. The counter advances first, and the stop check sees the
    // new value, so the closing result already carries the limit flag.
    function automatic void close_arg();
        logic [ARG_W-1:0] num;
        if (!arg_open)
            return;
        num       = arg_count;
        arg_count = arg_count + 1'b1;
        arg_open  = 1'b0;
        if (arg_count == stop_arg)
            halted = 1'b1;
        add_result('0, 1'b1, num);
    endfunction

    function automatic void clear_line();
        quoted    = 1'b0;
        slash_run = '0;
        arg_open  = 1'b0;
        arg_count = first_arg;
        halted    = 1'b0;
        saturated = 1'b0;
    endfunction

    // Works out every result that one accepted byte causes and queues them in order.
    function automatic void predict_item(logic [BYTE_W-1:0] c, logic eol_flag);
        logic             line_done;
        logic [RUN_W-1:0] run;
        token_result_t    tail;
        // A zero byte ends the line just like the end-of-line flag.
        line_done = eol_flag || (c == NUL_CH);
        burst = {};
        if (c != NUL_CH && !halted) begin
            if (c == BSLASH_CH) begin
                // Backslashes are only counted; what they mean depends on the next byte.
                if (slash_run < RUN_MAX)
                    slash_run = slash_run + 1'b1;
                else
                    saturated = 1'b1;
            end
            else begin
                run       = slash_run;
                slash_run = '0;
                if (c == QUOTE_CH) begin
                    // Half the run survives; an odd run escapes the quote itself.
                    emit_slashes(run >> 1);
                    if (run[0])
                        append_char(QUOTE_CH);
                    else
                        quoted = ~quoted;
                end
                else begin
                    emit_slashes(run);
                    if (!quoted && (c == SPACE_CH || (c >= TAB_CH && c <= CR_CH)))
                        close_arg();
                    else
                        append_char(c);
                end
            end
        end
        if (line_done) begin
            // A run still pending at the end of the line comes out literally.
            if (!halted) begin
                run       = slash_run;
                slash_run = '0;
                emit_slashes(run);
                close_arg();
            end
            clear_line();
        end
        if (burst.size() != 0) begin
            tail      = burst.pop_back();
            tail.last = 1'b1;
            burst.push_back(tail);
        end
        foreach (burst[i])
            expected_results.push_back(burst[i]);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void put_char(logic [BYTE_W-1:0] c, logic e);
        line_char_t lc;
        lc.ch  = c;
        lc.eol = e;
        pending_chars.push_back(lc);
        items_queued++;
    endfunction

    // A byte for a well-formed line: mostly letters, separators, quotes and backslashes,
    // never a zero byte so the line is not cut short.
    function automatic logic [BYTE_W-1:0] pick_char();
        int roll;
        roll = $urandom_range(99);
        if (roll < 34)
            return 8'(8'h61 + $urandom_range(25));
        else if (roll < 50)
            return $urandom_range(1) ? SPACE_CH : 8'(TAB_CH + $urandom_range(4));
        else if (roll < 62)
            return QUOTE_CH;
        else if (roll < 80)
            return BSLASH_CH;
        else if (roll < 92)
            return 8'($urandom_range(1, 255));
        else
            return 8'($urandom_range(128, 255));
    endfunction

    // Queues one line. A noisy line is raw bytes, zero included, with the end flag at
    // random; a clean line ends with the end flag or, now and then, with a zero byte.
    task automatic queue_line(int len, bit noisy);
        bit nul_end;
        nul_end = ($urandom_range(4) == 0);
        @(negedge clk);
        for (int i = 0; i < len; i++) begin
            if (noisy)
                put_char(8'($urandom_range(255)), $urandom_range(7) == 0);
            else
                put_char(pick_char(), (i == len - 1) && !nul_end);
        end
        if (!noisy && nul_end)
            put_char(NUL_CH, 1'b0);
    endtask

    // A token holding a long backslash run, closed by a quote, by a plain byte, or by
    // the line end on the last backslash. Runs past RUN_MAX saturate.
    task automatic queue_long_run(int n);
        int tail;
        tail = $urandom_range(2);
        @(negedge clk);
        put_char(8'h61, 1'b0);
        for (int i = 0; i < n; i++)
            put_char(BSLASH_CH, (tail == 2) && (i == n - 1));
        if (tail == 0) begin
            put_char(QUOTE_CH, 1'b0);
            put_char(8'h62, 1'b1);
        end
        else if (tail == 1) begin
            put_char(8'h63, 1'b1);
        end
    endtask

    // Register writes go out at a rising edge and are mirrored in the predictor.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ARG_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_START_INDEX) begin
            // The start index also reloads the argument counter right away.
            first_arg = value;
            arg_count = value;
        end
        else begin
            stop_arg = value;
        end
    endtask

    // Holds the sender until every queued byte has gone in and every expected result has
    // come out, then lets the block finish any byte that produces nothing.
    task automatic drain(int extra);
        while (pending_chars.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Sender: presents pending bytes, keeping data stable while stalled.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                void'(pending_chars.pop_front());
            if (pending_chars.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_chars[0].ch;
                s_tlast  <= pending_chars[0].eol;
            end
            else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on every input transaction and checks every output transaction.
    // The prediction comes first so that a same-edge result still finds its expectation.
    // ------------------------------------------------------------------
    task automatic compare_field(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk) begin : result_monitor
        token_result_t want;
        if (rst_n) begin
            if (s_tvalid && s_tready)
                predict_item(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t ns: result with none expected, expected nothing, actual data %h user %h last %b",
                             $time, m_tdata, m_tuser, m_tlast);
                end
                else begin
                    want = expected_results.pop_front();
                    compare_field("out_byte", want.out_byte, m_tdata[7:0]);
                    compare_field("arg_number", want.arg_number, m_tdata[15:8]);
                    compare_field("token_end", 8'(want.token_end), 8'(m_tuser[0]));
                    compare_field("limit_reached", 8'(want.limit_reached), 8'(m_tuser[1]));
                    compare_field("run_overflow", 8'(want.run_overflow), 8'(m_tuser[2]));
                    compare_field("last", 8'(want.last), 8'(m_tlast));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
        end
    end

    // Watchdog: a long stretch without any transaction means the block is hung.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("%0t ns: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("command_line_tokenizer verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin : sequence_main
        logic [ARG_W-1:0] phase_start[PHASES];
        logic [ARG_W-1:0] phase_limit[PHASES];
        int               mark;

        first_arg = START_INDEX_RESET;
        stop_arg  = ARG_LIMIT_RESET;
        clear_line();

        // Fixed settings first: the widest range, a wrap from 255 up to a limit of 1, a
        // wrap to a small limit, a quick stop, and a limit equal to the start, which only
        // stops after the counter wraps all the way round. The last two are random.
        phase_start = '{8'd0, 8'd255, 8'd250, 8'd5, 8'd10, 8'd0, 8'd0};
        phase_limit = '{8'd255, 8'd1, 8'd3, 8'd7, 8'd10, 8'd1, 8'd1};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed line under the reset settings. After the first token the start index
        // and limit are changed mid-line; the new start applies to the next token at once.
        @(negedge clk);
        put_char(8'h61, 1'b0);
        put_char(SPACE_CH, 1'b0);
        drain(SETTLE_CYCLES);
        write_reg(REG_START_INDEX, 8'd7);
        write_reg(REG_ARG_LIMIT, 8'd11);
        @(negedge clk);
        // Tab as separator, then high bytes as ordinary characters closed by a vertical tab.
        put_char(8'h62, 1'b0);
        put_char(TAB_CH, 1'b0);
        put_char(8'hFF, 1'b0);
        put_char(8'h80, 1'b0);
        put_char(VT_CH, 1'b0);
        // A quoted space, two backslashes before a quote (one survives and quoting
        // flips), three before a quote (one survives plus a literal quote), then close.
        put_char(QUOTE_CH, 1'b0);
        put_char(SPACE_CH, 1'b0);
        put_char(QUOTE_CH, 1'b0);
        put_char(BSLASH_CH, 1'b0);
        put_char(BSLASH_CH, 1'b0);
        put_char(QUOTE_CH, 1'b0);
        put_char(BSLASH_CH, 1'b0);
        put_char(BSLASH_CH, 1'b0);
        put_char(BSLASH_CH, 1'b0);
        put_char(QUOTE_CH, 1'b0);
        put_char(QUOTE_CH, 1'b0);
        put_char(SPACE_CH, 1'b0);
        // An empty quoted token is dropped.
        put_char(QUOTE_CH, 1'b0);
        put_char(QUOTE_CH, 1'b0);
        put_char(SPACE_CH, 1'b0);
        // A lone backslash at the line end is flushed literally, and closing that token
        // reaches the limit of 11.
        put_char(BSLASH_CH, 1'b1);
        // A zero byte ends the next line, and an end flag on a bare space gives nothing.
        put_char(8'h78, 1'b0);
        put_char(NUL_CH, 1'b0);
        put_char(SPACE_CH, 1'b1);
        put_char(NUL_CH, 1'b0);

        for (int p = 0; p < PHASES; p++) begin
            drain(SETTLE_CYCLES);
            if (p >= 5) begin
                phase_start[p] = 8'($urandom_range(255));
                phase_limit[p] = 8'($urandom_range(1, 255));
            end
            write_reg(REG_START_INDEX, phase_start[p]);
            write_reg(REG_ARG_LIMIT, phase_limit[p]);
            // The first phase runs with no idle cycles on either side.
            steady = (p == 0);
            mark   = items_queued;
            if (p == 0)
                queue_long_run(66);
            else if (p == 5)
                queue_long_run($urandom_range(60, 68));
            while (items_queued - mark < PHASE_ITEMS) begin
                // Now and then the sender waits for every result before the next line.
                if ($urandom_range(5) == 0)
                    drain(0);
                queue_line($urandom_range(1, 14), $urandom_range(99) < 15);
            end
        end
        steady = 1'b0;

        drain(SETTLE_CYCLES);
        if (errors == 0)
            $display("command_line_tokenizer verification clean");
        else
            $display("command_line_tokenizer verification failed");
        $finish;
    end

endmodule

// File: command_line_tokenizer.f
rtl/clt_pkg.sv
rtl/clt_out_stage.sv
rtl/command_line_tokenizer.sv
verif/testbench.sv
